>>> rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define L2_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// clocked assertion on clk_i and rst_ni
`define L2_ASSERT(lbl, prop) \
  `L2_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/l2cn_pkg.sv
// shared constants of the channel normaliser
package l2cn_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DevW    = 9;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CntW    = 7;
  localparam int unsigned SumW    = 22;
  localparam int unsigned MultW   = 24;
  localparam int unsigned RsqW    = 16;
  localparam int unsigned MulAW   = 32;
  localparam int unsigned MulBW   = 24;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IN_ZP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_ZP = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_OUT_ZP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MULT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_USE_SC   = 3'd4;

  localparam logic [MultW-1:0] MULT_RESET = 24'd65536;
  localparam logic [ByteW-1:0] BYTE_MAX   = 8'd255;

endpackage

>>> rtl/l2cn_if.sv
// handshake channels for input items and results
interface l2cn_in_if;
  import l2cn_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [ByteW-1:0] scale_byte;
  logic             last_in_pixel;
  modport source (output valid, data_byte, scale_byte, last_in_pixel, input ready);
  modport sink   (input valid, data_byte, scale_byte, last_in_pixel, output ready);
endinterface

interface l2cn_out_if;
  import l2cn_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [IdxW-1:0]  channel_index;
  logic             last_of_pixel;
  modport source (output valid, out_byte, channel_index, last_of_pixel, input ready);
  modport sink   (input valid, out_byte, channel_index, last_of_pixel, output ready);
endinterface

>>> rtl/l2cn_mul.sv
// shared registered multiplier
module l2cn_mul
  import l2cn_pkg::*;
(
  input  logic             clk_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_q;

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/l2_channel_normalize_u8.sv
// top level of the quantized l2 channel normaliser
// usage: channel bytes of one pixel arrive on in_i, one transfer per channel,
// with last_in_pixel on the final one (the MAX_CHANNELS-th closes it anyway).
// after each input transfer, the accumulate state adds the shared multiplier's
// square of the deviation into the running sum.
// on closing, a binary search finds the q1.15 reciprocal square root in up to
// 15 steps, each of two multiplier passes and a compare.
// then each channel result goes through a store read, three multiplier
// passes, rounding and its transfer on out_o, which waits for out_o.ready.
// in_i is not ready while the root search or emission runs.
// a stalled receiver holds the result register and the whole sequencer.
// reset clears the sum, the channel count and the sequencer and sets the
// configuration registers to their defaults; the stores need no clearing.
// configuration must be written through cfg_we_i only while the block is idle; the block itself does not enforce this.
module l2_channel_normalize_u8
  import l2cn_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  l2cn_in_if.sink            in_i,
  l2cn_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MultW-1:0]   cfg_data_i
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_RSQ  = 4'd2;
  localparam logic [3:0] S_RMUL = 4'd3;
  localparam logic [3:0] S_RCMP = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_M3   = 4'd8;
  localparam logic [3:0] S_RND  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // configuration registers
  logic [ByteW-1:0] in_zp_q, sc_zp_q, out_zp_q;
  logic [MultW-1:0] mult_q;
  logic             use_sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_zp_q  <= '0;
      sc_zp_q  <= '0;
      out_zp_q <= '0;
      mult_q   <= MULT_RESET;
      use_sc_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IN_ZP:    in_zp_q  <= cfg_data_i[ByteW-1:0];
        CFG_SCALE_ZP: sc_zp_q  <= cfg_data_i[ByteW-1:0];
        CFG_OUT_ZP:   out_zp_q <= cfg_data_i[ByteW-1:0];
        CFG_MULT:     mult_q   <= cfg_data_i;
        CFG_USE_SC:   use_sc_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [3:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic             close_q, close_d;
  logic             zero_q, zero_d;
  logic [RsqW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [IdxW-1:0]  k_q, k_d;
  logic             neg_q, neg_d;
  logic             ovld_q, ovld_d;
  logic [ByteW-1:0] obyte_q, obyte_d;
  logic             olast_q, olast_d;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;

  l2cn_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // input deviations
  logic             in_xfer;
  logic [DevW-1:0]  in_d, in_s;
  logic [ByteW-1:0] in_ad;
  assign in_xfer = in_i.valid && in_i.ready;
  assign in_d    = {1'b0, in_i.data_byte} - {1'b0, in_zp_q};
  assign in_s    = {1'b0, in_i.scale_byte} - {1'b0, sc_zp_q};
  assign in_ad   = in_d[DevW-1] ? ByteW'(-in_d) : in_d[ByteW-1:0];

  // deviation and scale store, written per transfer, read during emission
  logic [2*DevW-1:0] store_mem [StoreDepth];
  logic [2*DevW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      store_mem[count_q[IdxW-1:0]] <= {in_d, in_s};
    end
    if (state_q == S_RD) begin
      rd_q <= store_mem[k_q];
    end
  end

  // stored operands
  logic [DevW-1:0]  st_d, st_s;
  logic [ByteW-1:0] st_ad, st_as;
  assign st_d  = rd_q[2*DevW-1:DevW];
  assign st_s  = use_sc_q ? rd_q[DevW-1:0] : DevW'(1);
  assign st_ad = st_d[DevW-1] ? ByteW'(-st_d) : st_d[ByteW-1:0];
  assign st_as = st_s[DevW-1] ? ByteW'(-st_s) : st_s[ByteW-1:0];

  // root search midpoint
  logic [RsqW:0]   mid_sum;
  logic [RsqW-1:0] mid, tval;
  assign mid_sum = ({1'b0, lo_q} + {1'b0, hi_q} + (RsqW+1)'(1)) >> 1;
  assign mid     = mid_sum[RsqW-1:0];
  assign tval    = {mid[RsqW-2:0], 1'b0} - RsqW'(1);

  // rounding and clamping
  logic [ProdW:0]   rnd;
  logic [ProdW-31:0] qv;
  logic [ProdW-30:0] qpos;
  logic [ByteW-1:0] res;
  assign rnd  = {1'b0, prod} + (ProdW+1)'(64'd1 << 30);
  assign qv   = rnd[ProdW:31];
  assign qpos = {1'b0, qv} + (ProdW-29)'(out_zp_q);

  always_comb begin
    if (zero_q) begin
      res = out_zp_q;
    end else if (neg_q) begin
      res = (qv >= (ProdW-30)'(out_zp_q)) ? '0 : out_zp_q - qv[ByteW-1:0];
    end else begin
      res = (qpos > (ProdW-29)'(BYTE_MAX)) ? BYTE_MAX : qpos[ByteW-1:0];
    end
  end

  logic [SumW-1:0] sum_acc;
  assign sum_acc = sum_q + SumW'(prod[15:0]);

  // sequencer and operand selection
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sum_d   = sum_q;
    close_d = close_q;
    zero_d  = zero_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    k_d     = k_q;
    neg_d   = neg_q;
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    mul_a   = MulAW'(in_ad);
    mul_b   = MulBW'(in_ad);
    unique case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          count_d = count_q + CntW'(1);
          close_d = in_i.last_in_pixel || (count_q + CntW'(1) >= CntW'(MAX_CHANNELS));
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d = sum_acc;
        if (!close_q) begin
          state_d = S_LOAD;
        end else begin
          zero_d  = (sum_acc == '0);
          lo_d    = RsqW'(1);
          hi_d    = RsqW'(32768);
          k_d     = '0;
          state_d = S_RSQ;
        end
      end
      S_RSQ: begin
        mul_a = MulAW'(tval);
        mul_b = MulBW'(tval);
        state_d = (lo_q < hi_q && !zero_q) ? S_RMUL : S_RD;
      end
      S_RMUL: begin
        mul_a = prod[MulAW-1:0];
        mul_b = MulBW'(sum_q);
        state_d = S_RCMP;
      end
      S_RCMP: begin
        if (prod <= ProdW'(64'h1_0000_0000)) lo_d = mid;
        else hi_d = mid - RsqW'(1);
        state_d = S_RSQ;
      end
      S_RD: begin
        state_d = S_M1;
      end
      S_M1: begin
        mul_a   = MulAW'(st_ad);
        mul_b   = MulBW'(st_as);
        neg_d   = st_d[DevW-1] ^ st_s[DevW-1];
        state_d = S_M2;
      end
      S_M2: begin
        mul_a   = MulAW'(prod[15:0]);
        mul_b   = MulBW'(lo_q);
        state_d = S_M3;
      end
      S_M3: begin
        mul_a   = prod[MulAW-1:0];
        mul_b   = mult_q;
        state_d = S_RND;
      end
      S_RND: begin
        obyte_d = res;
        olast_d = ({1'b0, k_q} + CntW'(1)) == count_q;
        ovld_d  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          ovld_d = 1'b0;
          if (olast_q) begin
            sum_d   = '0;
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + IdxW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      sum_q   <= '0;
      ovld_q  <= 1'b0;
      close_q <= 1'b0;
      zero_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      ovld_q  <= ovld_d;
      close_q <= close_d;
      zero_q  <= zero_d;
      k_q     <= k_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    neg_q   <= neg_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign in_i.ready          = (state_q == S_LOAD);
  assign out_o.valid         = ovld_q;
  assign out_o.out_byte      = obyte_q;
  assign out_o.channel_index = k_q;
  assign out_o.last_of_pixel = olast_q;

endmodule

>>> rtl/l2cn_checker.sv
// port checker for the channel normaliser, bound to the top level
`include "assert_macros.svh"

module l2cn_checker
  import l2cn_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic [IdxW-1:0]  out_index_i,
  input logic             out_last_i
);

  // result payload as one vector
  logic [ByteW+IdxW:0] out_pay;
  assign out_pay = {out_byte_i, out_index_i, out_last_i};

  // no input transfer while a result is pending
  `L2_ASSERT(a_no_in_while_out, out_valid_i |-> !in_ready_i)

  // a stalled result holds
  `L2_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pay))

  // after a non-final result the pixel is still being emitted
  `L2_ASSERT(a_pixel_busy, out_valid_i && out_ready_i && !out_last_i |=> !in_ready_i)

  // an input transfer is followed by a cycle without readiness
  `L2_ASSERT(a_acc_cycle, in_valid_i && in_ready_i |=> !in_ready_i && !out_valid_i)

endmodule

bind l2_channel_normalize_u8 l2cn_checker u_l2cn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_index_i (out_o.channel_index),
  .out_last_i  (out_o.last_of_pixel)
);
